FILE: rtl/gsd_pkg.sv
`timescale 1ns / 1ps

package gsd_pkg;

    // Field and register widths.
    localparam int LFSR_W     = 31;
    localparam int LLR_W      = 16;
    localparam int ID_W       = 10;
    localparam int SKIP_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int CNT_W      = 8;

    // The fixed 1600-bit offset is 50 words of 32 bits.
    localparam int WORD_BITS       = 32;
    localparam int WORD_SHIFT      = 5;
    localparam int WORD_ROUND      = 31;
    localparam int BASE_SKIP_WORDS = 1600 / WORD_BITS;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IDENTITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP     = 2'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic seed;   // load both registers and the skip word count
        logic skip;   // advance both registers by one word
        logic step;   // take one request and advance by one bit
    } gsd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip_last;  // the current skip word is the final one
    } gsd_status_t;

    // Advance x1 by 32 bits: x(n+31) = x(n+3) ^ x(n).
    function automatic logic [LFSR_W-1:0] adv_word_x1(input logic [LFSR_W-1:0] cur);
        logic [LFSR_W+WORD_BITS-1:0] seq;
        seq = '0;
        seq[LFSR_W-1:0] = cur;
        for (int k = LFSR_W; k < LFSR_W + WORD_BITS; k++)
        begin
            seq[k] = seq[k-28] ^ seq[k-31];
        end
        return seq[LFSR_W+WORD_BITS-1:WORD_BITS];
    endfunction

    // Advance x2 by 32 bits: x(n+31) = x(n+3) ^ x(n+2) ^ x(n+1) ^ x(n).
    function automatic logic [LFSR_W-1:0] adv_word_x2(input logic [LFSR_W-1:0] cur);
        logic [LFSR_W+WORD_BITS-1:0] seq;
        seq = '0;
        seq[LFSR_W-1:0] = cur;
        for (int k = LFSR_W; k < LFSR_W + WORD_BITS; k++)
        begin
            seq[k] = seq[k-28] ^ seq[k-29] ^ seq[k-30] ^ seq[k-31];
        end
        return seq[LFSR_W+WORD_BITS-1:WORD_BITS];
    endfunction

endpackage

FILE: rtl/gsd_ctrl.sv
`timescale 1ns / 1ps

module gsd_ctrl
    import gsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        block_end,
    input  logic        out_ready,
    input  logic        cfg_write,
    input  gsd_status_t status,
    output gsd_cmd_t    cmd,
    output logic        in_ready,
    output logic        out_valid
);

    typedef enum logic [1:0] {
        ST_SEED,
        ST_SKIP,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   active_reg;
    logic   active_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    // A request is taken in RUN once the output register is free or draining.
    assign in_ready = (state_reg == ST_RUN) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign cmd.seed  = (state_reg == ST_SEED);
    assign cmd.skip  = (state_reg == ST_SKIP);
    assign cmd.step  = accept;
    assign out_valid = out_valid_reg;

    // Next state. A configuration write between blocks restarts the run-up
    // so the next block sees the new values.
    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_SEED:
            begin
                active_next = 1'b0;
                if (!cfg_write)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (cfg_write)
                begin
                    state_next = ST_SEED;
                end
                else if (status.skip_last)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (accept)
                begin
                    active_next = !block_end;
                    if (block_end)
                    begin
                        state_next = ST_SEED;
                    end
                end
                else if (cfg_write && !active_reg)
                begin
                    state_next = ST_SEED;
                end
            end
            default:
            begin
                state_next = ST_SEED;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SEED;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/gsd_datapath.sv
`timescale 1ns / 1ps

module gsd_datapath
    import gsd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  gsd_cmd_t                     cmd,
    input  logic                         cfg_write,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic signed [LLR_W-1:0]      llr_in,
    input  logic                         block_end,
    output gsd_status_t                  status,
    output logic signed [LLR_W-1:0]      llr_out,
    output logic                         block_done
);

    logic [ID_W-1:0]         identity_reg;
    logic [SKIP_W-1:0]       skip_len_reg;
    logic [LFSR_W-1:0]       x1_reg;
    logic [LFSR_W-1:0]       x2_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [LLR_W-1:0] llr_out_reg;
    logic                    block_done_reg;
    logic [SKIP_W:0]         skip_round;
    logic [CNT_W-1:0]        skip_words;
    logic                    seq_bit;
    logic signed [LLR_W-1:0] llr_next;

    // Extra words to skip: ceil(M / 32).
    assign skip_round = {1'b0, skip_len_reg} + (SKIP_W + 1)'(WORD_ROUND);
    assign skip_words = CNT_W'(skip_round >> WORD_SHIFT);

    assign status.skip_last = (cnt_reg == '0);

    // Negate where the sequence bit is set, saturating the most negative value.
    assign seq_bit = x1_reg[0] ^ x2_reg[0];
    always_comb
    begin
        if (!seq_bit)
        begin
            llr_next = llr_in;
        end
        else if (llr_in == {1'b1, {(LLR_W-1){1'b0}}})
        begin
            llr_next = {1'b0, {(LLR_W-1){1'b1}}};
        end
        else
        begin
            llr_next = -llr_in;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            identity_reg <= '0;
            skip_len_reg <= SKIP_W'(1792);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IDENTITY: identity_reg <= cfg_data[ID_W-1:0];
                REG_SKIP:     skip_len_reg <= cfg_data[SKIP_W-1:0];
                default:      ;
            endcase
        end
    end

    // Sequence generators and skip word counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg  <= LFSR_W'(1);
            x2_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.seed)
        begin
            x1_reg  <= LFSR_W'(1);
            x2_reg  <= LFSR_W'(identity_reg);
            cnt_reg <= CNT_W'(BASE_SKIP_WORDS - 1) + skip_words;
        end
        else if (cmd.skip)
        begin
            x1_reg  <= adv_word_x1(x1_reg);
            x2_reg  <= adv_word_x2(x2_reg);
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        else if (cmd.step)
        begin
            x1_reg <= {x1_reg[0] ^ x1_reg[3], x1_reg[LFSR_W-1:1]};
            x2_reg <= {x2_reg[0] ^ x2_reg[1] ^ x2_reg[2] ^ x2_reg[3], x2_reg[LFSR_W-1:1]};
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            llr_out_reg    <= llr_next;
            block_done_reg <= block_end;
        end
    end

    assign llr_out    = llr_out_reg;
    assign block_done = block_done_reg;

endmodule

FILE: rtl/gold_sequence_llr_descrambler_unit.sv
`timescale 1ns / 1ps
// Latency: a result is valid the cycle after its request is accepted.
// Throughput: one soft bit per cycle within a block while out_ready does not stall the output.
// Block start: the run-up skips the 1600-bit offset plus ceil(M/32) words, one word of
// 32 bits per cycle; it starts after reset, after the last soft bit of a block, and again
// after a register write between blocks. Requests are held off until it finishes.
// Reset (rst_n low, asynchronous) clears control, registers and generators to defaults.
module gold_sequence_llr_descrambler_unit
    import gsd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [LLR_W-1:0] llr_in,
    input  logic                    block_end,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [LLR_W-1:0] llr_out,
    output logic                    block_done,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    gsd_cmd_t    cmd;
    gsd_status_t status;
    logic        cfg_write;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    gsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .block_end (block_end),
        .out_ready (out_ready),
        .cfg_write (cfg_write),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    gsd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .llr_in     (llr_in),
        .block_end  (block_end),
        .status     (status),
        .llr_out    (llr_out),
        .block_done (block_done)
    );

    // An accepted request always yields a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted request produced no result");

    // No request is taken while the generators are seeded or skipping.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.seed || cmd.skip) |-> !in_ready)
        else $error("request accepted during sequence run-up");

    // The last soft bit of a block triggers a fresh seed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && block_end) |=> cmd.seed)
        else $error("block end did not restart the sequence");

    // Only one datapath command is active at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.seed, cmd.skip, cmd.step}))
        else $error("conflicting datapath commands");

endmodule
